/* hdl/scp_pkg.sv */
`timescale 1ns / 1ps

package scp_pkg;

  localparam int IDX_BITS   = 32;
  localparam int VAL_BITS   = 32;
  localparam int CNT_BITS   = 32;
  localparam int OFS_BITS   = 7;
  localparam int BB_BITS    = 3;
  localparam logic [BB_BITS-1:0] BB_RESET = 3'd7;

  localparam logic KIND_ELEM = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic [IDX_BITS-1:0] row_index;
    logic [IDX_BITS-1:0] col_index;
    logic [VAL_BITS-1:0] value_bits;
    logic                final_entry;
  } item_t;

  typedef struct packed {
    logic                record_kind;
    logic [OFS_BITS-1:0] elem_row;
    logic [OFS_BITS-1:0] elem_col;
    logic [VAL_BITS-1:0] value_out;
    logic                starts_block;
    logic [IDX_BITS-1:0] block_row;
    logic [IDX_BITS-1:0] block_col;
    logic [CNT_BITS-1:0] position;
    logic [CNT_BITS-1:0] max_block_count;
    logic                last;
  } record_t;

  function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
    return (&v) ? v : v + {{(CNT_BITS-1){1'b0}}, 1'b1};
  endfunction

endpackage

/* hdl/scp_if.sv */
`timescale 1ns / 1ps

interface scp_item_if;
  logic                          valid;
  logic                          ready;
  logic [scp_pkg::IDX_BITS-1:0]  row_index;
  logic [scp_pkg::IDX_BITS-1:0]  col_index;
  logic [scp_pkg::VAL_BITS-1:0]  value_bits;
  logic                          final_entry;

  modport source (output valid, row_index, col_index, value_bits, final_entry,
                  input ready);
  modport sink (input valid, row_index, col_index, value_bits, final_entry,
                output ready);
endinterface

interface scp_result_if;
  logic                          valid;
  logic                          ready;
  logic                          record_kind;
  logic [scp_pkg::OFS_BITS-1:0]  elem_row;
  logic [scp_pkg::OFS_BITS-1:0]  elem_col;
  logic [scp_pkg::VAL_BITS-1:0]  value_out;
  logic                          starts_block;
  logic [scp_pkg::IDX_BITS-1:0]  block_row;
  logic [scp_pkg::IDX_BITS-1:0]  block_col;
  logic [scp_pkg::CNT_BITS-1:0]  position;
  logic [scp_pkg::CNT_BITS-1:0]  max_block_count;
  logic                          last;

  modport source (output valid, record_kind, elem_row, elem_col, value_out,
                  starts_block, block_row, block_col, position,
                  max_block_count, last,
                  input ready);
  modport sink (input valid, record_kind, elem_row, elem_col, value_out,
                starts_block, block_row, block_col, position,
                max_block_count, last,
                output ready);
endinterface

interface scp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [scp_pkg::BB_BITS-1:0]   block_bits;

  modport source (output valid, block_bits, input ready);
  modport sink (input valid, block_bits, output ready);
endinterface

/* hdl/scp_track.sv */
`timescale 1ns / 1ps

// Run state: block detection, per-block and total counts. Records are
// formed from the current state; state moves on when take is high.
module scp_track (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [scp_pkg::BB_BITS-1:0]  block_bits,
  input  scp_pkg::item_t               item,
  input  logic                         take,
  output scp_pkg::record_t             elem,
  output scp_pkg::record_t             summary
);

  logic [scp_pkg::IDX_BITS-1:0] prior_row;
  logic [scp_pkg::IDX_BITS-1:0] prior_col;
  logic                         first_pending;
  logic [scp_pkg::CNT_BITS-1:0] nonzero_count;
  logic [scp_pkg::CNT_BITS-1:0] block_count;
  logic [scp_pkg::CNT_BITS-1:0] block_max;

  logic [scp_pkg::IDX_BITS-1:0] brow;
  logic [scp_pkg::IDX_BITS-1:0] bcol;
  logic [scp_pkg::OFS_BITS:0]   emask;
  logic                         opens;
  logic [scp_pkg::CNT_BITS-1:0] block_count_next;
  logic [scp_pkg::CNT_BITS-1:0] block_max_next;
  logic [scp_pkg::CNT_BITS-1:0] nonzero_count_next;

  always_comb begin
    brow  = item.row_index >> block_bits;
    bcol  = item.col_index >> block_bits;
    emask = ({{scp_pkg::OFS_BITS{1'b0}}, 1'b1} << block_bits)
            - {{scp_pkg::OFS_BITS{1'b0}}, 1'b1};
    opens = first_pending || (brow != prior_row) || (bcol != prior_col);
    block_count_next = opens ? {{(scp_pkg::CNT_BITS-1){1'b0}}, 1'b1}
                             : scp_pkg::sat_inc(block_count);
    block_max_next = (block_count_next > block_max) ? block_count_next : block_max;
    nonzero_count_next = scp_pkg::sat_inc(nonzero_count);

    elem = '0;
    elem.record_kind  = scp_pkg::KIND_ELEM;
    elem.elem_row     = item.row_index[scp_pkg::OFS_BITS-1:0]
                        & emask[scp_pkg::OFS_BITS-1:0];
    elem.elem_col     = item.col_index[scp_pkg::OFS_BITS-1:0]
                        & emask[scp_pkg::OFS_BITS-1:0];
    elem.value_out    = item.value_bits;
    elem.starts_block = opens;
    elem.block_row    = brow;
    elem.block_col    = bcol;
    elem.position     = nonzero_count;

    summary = '0;
    summary.record_kind     = scp_pkg::KIND_END;
    summary.position        = nonzero_count_next;
    summary.max_block_count = block_max_next;
    summary.last            = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst || (take && item.final_entry)) begin
      prior_row     <= '0;
      prior_col     <= '0;
      first_pending <= 1'b1;
      nonzero_count <= '0;
      block_count   <= '0;
      block_max     <= '0;
    end else if (take) begin
      if (opens) begin
        prior_row <= brow;
        prior_col <= bcol;
      end
      first_pending <= 1'b0;
      nonzero_count <= nonzero_count_next;
      block_count   <= block_count_next;
      block_max     <= block_max_next;
    end
  end

endmodule

/* hdl/sparse_coo_block_partitioner.sv */
`timescale 1ns / 1ps

// Sparse COO block partitioner.
// item:   nonzeros (row, column, value word, final flag), valid/ready.
// result: element records, plus one end record after the final nonzero
//         carrying the total count and the largest per-block count.
// cfg:    writes block_bits (log2 of the block edge); always ready. Write
//         only while no request is in flight.
// Path: an accepted request is held in the input register, then its element
//   record is loaded into the result register and shows on result.
// Throughput: one request per cycle while result is not stalled. A final
//   nonzero yields an element record then an end record, so the request
//   after it waits at the input register while the end record goes out.
// Reset (rst, synchronous): clears the pipeline and run state, block_bits
//   returns to 7. When a final nonzero is taken, the run state clears the same way.
// Receiver stall: the result register holds; the input register takes one
//   more request, then item.ready drops until result drains.
module sparse_coo_block_partitioner (
  input  logic                clk,
  input  logic                rst,
  scp_item_if.sink            item,
  scp_result_if.source        result,
  scp_cfg_if.sink             cfg
);

  logic [scp_pkg::BB_BITS-1:0] block_bits;

  scp_pkg::item_t   item_q;
  logic             item_valid;
  scp_pkg::record_t out_q;
  logic             out_valid;
  scp_pkg::record_t end_q;
  logic             end_valid;

  scp_pkg::record_t elem;
  scp_pkg::record_t summary;
  logic             out_load;
  logic             take;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_bits <= scp_pkg::BB_RESET;
    end else if (cfg.valid) begin
      block_bits <= cfg.block_bits;
    end
  end

  assign out_load   = !out_valid || result.ready;
  // a pending end record goes out before the next element
  assign take       = item_valid && out_load && !end_valid;
  assign item.ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (item.ready) begin
      item_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      item_q.row_index   <= item.row_index;
      item_q.col_index   <= item.col_index;
      item_q.value_bits  <= item.value_bits;
      item_q.final_entry <= item.final_entry;
    end
  end

  scp_track u_track (
    .clk        (clk),
    .rst        (rst),
    .block_bits (block_bits),
    .item       (item_q),
    .take       (take),
    .elem       (elem),
    .summary    (summary)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      end_valid <= 1'b0;
    end else if (out_load && end_valid) begin
      out_valid <= 1'b1;
      end_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
      end_valid <= item_q.final_entry;
    end else if (out_load) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && end_valid) begin
      out_q <= end_q;
    end else if (take) begin
      out_q <= elem;
      if (item_q.final_entry) begin
        end_q <= summary;
      end
    end
  end

  assign result.valid           = out_valid;
  assign result.record_kind     = out_q.record_kind;
  assign result.elem_row        = out_q.elem_row;
  assign result.elem_col        = out_q.elem_col;
  assign result.value_out       = out_q.value_out;
  assign result.starts_block    = out_q.starts_block;
  assign result.block_row       = out_q.block_row;
  assign result.block_col       = out_q.block_col;
  assign result.position        = out_q.position;
  assign result.max_block_count = out_q.max_block_count;
  assign result.last            = out_q.last;

  a_end_behind_elem: assert property (@(posedge clk) disable iff (rst)
    end_valid |-> out_valid)
    else $error("end record pending without an element record ahead");

  a_final_splits: assert property (@(posedge clk) disable iff (rst)
    take && item_q.final_entry |=> end_valid && out_q.record_kind == scp_pkg::KIND_ELEM)
    else $error("final nonzero did not queue an end record");

  a_no_take_while_end: assert property (@(posedge clk) disable iff (rst)
    end_valid && !result.ready |=> end_valid && $stable(end_q))
    else $error("end record lost under stall");

  a_last_is_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_q.last |-> out_q.record_kind == scp_pkg::KIND_END)
    else $error("last flag on an element record");

endmodule
